FILE: hw/rtl/i2cee_pkg.sv
// Shared codes, constants and types of the I2C EEPROM slave.
`default_nettype none
package i2cee_pkg;

  // Event codes of an input word
  localparam logic [1:0] CMD_SCL  = 2'd0;
  localparam logic [1:0] CMD_SDA  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Bus phase codes
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START    = 4'd1;
  localparam logic [3:0] PH_RX_CMD   = 4'd2;
  localparam logic [3:0] PH_ACK_CMD  = 4'd3;
  localparam logic [3:0] PH_RX_ADDR  = 4'd4;
  localparam logic [3:0] PH_ACK_ADDR = 4'd5;
  localparam logic [3:0] PH_RX_DATA  = 4'd6;
  localparam logic [3:0] PH_ACK_WR   = 4'd7;
  localparam logic [3:0] PH_WRPEND   = 4'd8;
  localparam logic [3:0] PH_TX_DATA  = 4'd9;
  localparam logic [3:0] PH_ACK_RD   = 4'd10;

  // Control byte decode
  localparam logic [7:0] CTRL_MASK = 8'hF0;
  localparam logic [7:0] CTRL_ID   = 8'hA0;
  localparam logic [7:0] CTRL_READ = 8'h01;

  localparam logic [3:0]  BYTE_BITS      = 4'd8;
  localparam logic [15:0] WRITE_TIME_RST = 16'd1000;

  // One result word
  typedef struct packed {
    logic sda_drive;
    logic busy_res;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/i2cee_if.sv
// Handshake interfaces for the event words and the result words.
`default_nettype none
interface i2cee_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       level;

  modport source (output valid, output command, output level, input ready);
  modport sink   (input valid, input command, input level, output ready);
endinterface

interface i2cee_out_if;
  logic valid;
  logic ready;
  logic sda_drive;
  logic busy_res;

  modport source (output valid, output sda_drive, output busy_res, input ready);
  modport sink   (input valid, input sda_drive, input busy_res, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/i2c_eeprom_slave.sv
// Top level of the I2C EEPROM slave: handshake, register, engine and store.
//
// Use: in_i carries event words (command: SCL change, SDA change or time
// tick; level: new line level). out_o gives one result word per event:
// the slave's SDA drive and the busy flag, both as they stand after the
// event. cfg_we_i/cfg_wdata_i write write_time, the busy period in ticks.
// Latency: a result is shown the cycle after its event is taken.
// Throughput: one event per cycle while out_o.ready is high. The byte
// store is a synchronous memory whose read port always tracks the next
// word address, so a read byte is ready by the time a falling SCL edge
// needs it; a write in the previous cycle is forwarded.
// Reset: engine idle, both lines high, SDA released, not busy, write_time
// 1000. The store reads as all zero straight after reset through
// per-entry valid bits; there is no clearing pass.
// Stall: the output register holds its word while out_o.ready is low; a new
// event is taken whenever that register is empty or being emptied. The user
// writes configuration only while no event is in flight; not enforced.
`default_nettype none
module i2c_eeprom_slave #(
  parameter int MEM_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cee_in_if.sink          in_i,
  i2cee_out_if.source       out_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic              accept;
  logic [15:0]       write_time_q;
  logic              out_valid_q;
  i2cee_pkg::res_t   res_d, res_q;
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [7:0]        st_wdata;
  logic [AW-1:0]     st_raddr;
  logic [7:0]        rd_byte;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Hold the write time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_time_q <= i2cee_pkg::WRITE_TIME_RST;
    end else if (cfg_we_i) begin
      write_time_q <= cfg_wdata_i;
    end
  end

  i2cee_ctrl #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_valid_i   (accept),
    .command_i    (in_i.command),
    .level_i      (in_i.level),
    .write_time_i (write_time_q),
    .rd_byte_i    (rd_byte),
    .st_we_o      (st_we),
    .st_waddr_o   (st_waddr),
    .st_wdata_o   (st_wdata),
    .st_raddr_o   (st_raddr),
    .res_o        (res_d)
  );

  i2cee_store #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (rd_byte)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.sda_drive = res_q.sda_drive;
  assign out_o.busy_res  = res_q.busy_res;

endmodule
`default_nettype wire

FILE: hw/rtl/i2cee_store.sv
// Byte store: synchronous memory with per-entry valid bits and write forwarding.
`default_nettype none
module i2cee_store #(
  parameter int MEM_DEPTH = 16,
  parameter int AW        = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [7:0]           rd_q;
  logic                 rvld_q;
  logic                 fwd_q;
  logic [7:0]           fwd_data_q;

  // Write and read the array, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q       <= mem[raddr_i];
    fwd_data_q <= wdata_i;
  end

  // Track written entries; catch a write to the entry being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
      fwd_q  <= we_i && (waddr_i == raddr_i);
    end
  end

  // Unwritten entries read as zero
  assign rdata_o = fwd_q ? fwd_data_q : (rvld_q ? rd_q : 8'h00);

endmodule
`default_nettype wire

FILE: hw/rtl/i2cee_ctrl.sv
// Bus phase engine: line edges, byte shifting, busy timer and store access.
`default_nettype none
module i2cee_ctrl #(
  parameter int MEM_DEPTH = 16,
  parameter int AW        = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ev_valid_i,
  input  logic [1:0]       command_i,
  input  logic             level_i,
  input  logic [15:0]      write_time_i,
  input  logic [7:0]       rd_byte_i,
  output logic             st_we_o,
  output logic [AW-1:0]    st_waddr_o,
  output logic [7:0]       st_wdata_o,
  output logic [AW-1:0]    st_raddr_o,
  output i2cee_pkg::res_t  res_o
);

  localparam logic [8:0] LAST_ADDR = 9'(MEM_DEPTH - 1);

  logic [3:0]    phase_q, phase_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [7:0]    shift_q, shift_d;
  logic [AW-1:0] waddr_q, waddr_d;
  logic          scl_q, scl_d;
  logic          sda_q, sda_d;
  logic          drive_q, drive_d;
  logic          busy_q, busy_d;
  logic [15:0]   ticks_q, ticks_d;

  logic [AW-1:0] mod_tab [256];
  logic [3:0]    cnt_inc;
  logic [3:0]    cnt_dec;
  logic [7:0]    shift_in;
  logic [AW-1:0] waddr_inc;

  // Reduce a byte to a word address
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = AW'(g % MEM_DEPTH);
  end

  assign cnt_inc   = cnt_q + 4'd1;
  assign cnt_dec   = cnt_q - 4'd1;
  assign shift_in  = {shift_q[6:0], sda_q};
  assign waddr_inc = (9'(waddr_q) == LAST_ADDR) ? '0 : waddr_q + 1'b1;

  // Advance the state by one event
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    waddr_d    = waddr_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    drive_d    = drive_q;
    busy_d     = busy_q;
    ticks_d    = ticks_q;
    st_we_o    = 1'b0;
    if (ev_valid_i) begin
      case (command_i)
        i2cee_pkg::CMD_SCL: begin
          if (level_i != scl_q) begin
            scl_d = level_i;
            if (!level_i) begin
              case (phase_q)
                i2cee_pkg::PH_IDLE: begin
                  drive_d = 1'b1;
                end
                i2cee_pkg::PH_START: begin
                  drive_d = 1'b1;
                  phase_d = i2cee_pkg::PH_RX_CMD;
                end
                i2cee_pkg::PH_RX_CMD: begin
                  shift_d = shift_in;
                  cnt_d   = cnt_inc;
                  if (cnt_inc == i2cee_pkg::BYTE_BITS) begin
                    if ((shift_in & i2cee_pkg::CTRL_MASK) == i2cee_pkg::CTRL_ID) begin
                      phase_d = i2cee_pkg::PH_ACK_CMD;
                      drive_d = 1'b0;
                    end else begin
                      phase_d = i2cee_pkg::PH_IDLE;
                    end
                  end
                end
                i2cee_pkg::PH_ACK_CMD: begin
                  drive_d = 1'b1;
                  if ((shift_q & i2cee_pkg::CTRL_READ) != 8'h00) begin
                    phase_d = i2cee_pkg::PH_TX_DATA;
                    cnt_d   = i2cee_pkg::BYTE_BITS - 4'd1;
                    shift_d = rd_byte_i;
                    drive_d = rd_byte_i[7];
                  end else begin
                    phase_d = i2cee_pkg::PH_RX_ADDR;
                    cnt_d   = 4'd0;
                    shift_d = 8'h00;
                  end
                end
                i2cee_pkg::PH_RX_ADDR: begin
                  shift_d = shift_in;
                  cnt_d   = cnt_inc;
                  if (cnt_inc == i2cee_pkg::BYTE_BITS) begin
                    drive_d = 1'b0;
                    phase_d = i2cee_pkg::PH_ACK_ADDR;
                    waddr_d = mod_tab[shift_in];
                  end
                end
                i2cee_pkg::PH_ACK_ADDR: begin
                  drive_d = 1'b1;
                  phase_d = i2cee_pkg::PH_RX_DATA;
                  cnt_d   = 4'd0;
                  shift_d = 8'h00;
                end
                i2cee_pkg::PH_RX_DATA: begin
                  shift_d = shift_in;
                  cnt_d   = cnt_inc;
                  if (cnt_inc == i2cee_pkg::BYTE_BITS) begin
                    drive_d = 1'b0;
                    phase_d = i2cee_pkg::PH_ACK_WR;
                  end
                end
                i2cee_pkg::PH_ACK_WR: begin
                  drive_d = 1'b1;
                  phase_d = i2cee_pkg::PH_WRPEND;
                end
                i2cee_pkg::PH_WRPEND: begin
                  // a further data byte starts with this edge's bit
                  shift_d = {7'd0, sda_q};
                  cnt_d   = 4'd1;
                  phase_d = i2cee_pkg::PH_RX_DATA;
                end
                i2cee_pkg::PH_TX_DATA: begin
                  if (cnt_q == 4'd0) begin
                    drive_d = 1'b1;
                    waddr_d = waddr_inc;
                    phase_d = i2cee_pkg::PH_ACK_RD;
                  end else begin
                    cnt_d   = cnt_dec;
                    drive_d = shift_q[cnt_dec[2:0]];
                  end
                end
                i2cee_pkg::PH_ACK_RD: begin
                  // master ACK: drive the next byte's top bit at once
                  if (!sda_q) begin
                    phase_d = i2cee_pkg::PH_TX_DATA;
                    cnt_d   = i2cee_pkg::BYTE_BITS - 4'd1;
                    shift_d = rd_byte_i;
                    drive_d = rd_byte_i[7];
                  end else begin
                    phase_d = i2cee_pkg::PH_IDLE;
                  end
                end
                default: begin
                  drive_d = 1'b1;
                end
              endcase
            end
          end
        end
        i2cee_pkg::CMD_SDA: begin
          if (level_i != sda_q) begin
            sda_d = level_i;
            if (scl_q) begin
              if (level_i) begin
                // stop: commit a pending byte
                if (phase_q == i2cee_pkg::PH_WRPEND) begin
                  st_we_o = 1'b1;
                  if (write_time_i != 16'd0) begin
                    busy_d  = 1'b1;
                    ticks_d = write_time_i;
                  end
                end
                phase_d = i2cee_pkg::PH_IDLE;
              end else if (!busy_q) begin
                phase_d = i2cee_pkg::PH_START;
                cnt_d   = 4'd0;
                shift_d = 8'h00;
              end
            end
          end
        end
        i2cee_pkg::CMD_TICK: begin
          if (busy_q) begin
            if (ticks_q <= 16'd1) begin
              ticks_d = 16'd0;
              busy_d  = 1'b0;
            end else begin
              ticks_d = ticks_q - 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Keep the store's read port on the next word address
  assign st_waddr_o = waddr_q;
  assign st_wdata_o = shift_q;
  assign st_raddr_o = waddr_d;

  assign res_o.sda_drive = drive_d;
  assign res_o.busy_res  = busy_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cee_pkg::PH_IDLE;
      cnt_q   <= 4'd0;
      shift_q <= 8'h00;
      waddr_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drive_q <= 1'b1;
      busy_q  <= 1'b0;
      ticks_q <= 16'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      waddr_q <= waddr_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drive_q <= drive_d;
      busy_q  <= busy_d;
      ticks_q <= ticks_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/i2cee_checker.sv
// Port-level checks of the I2C EEPROM slave, bound to the top level.
`default_nettype none
module i2cee_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // Hold a result word while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // Every taken event gives a result word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("taken event gave no result word");

  // No result word without an event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_i) && !(out_valid_i && !out_ready_i) |=> !out_valid_i)
    else $error("result word without an event");

  // An empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output stage");

endmodule

bind i2c_eeprom_slave i2cee_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
`default_nettype wire

FILE: test/i2c_eeprom_slave_tb.sv
// Self-checking testbench for the I2C EEPROM slave: bus transactions against a shadow model.
`timescale 1ns / 100ps
module i2c_eeprom_slave_tb;

  localparam int          MEM_DEPTH   = 16;
  localparam int          SH_AW       = $clog2(MEM_DEPTH);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE_CYC  = 5;
  localparam int          MAX_REPORTS = 10;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic        clk;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  i2cee_in_if  ev_if ();
  i2cee_out_if res_if ();

  i2c_eeprom_slave #(
    .MEM_DEPTH (MEM_DEPTH)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_i        (ev_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow copy of the slave state
  logic [3:0]  sh_phase;
  logic [3:0]  sh_bits;
  logic [7:0]  sh_shift;
  logic [7:0]  sh_addr;
  logic        sh_scl;
  logic        sh_sda;
  logic        sh_drv;
  logic        sh_busy;
  logic [15:0] sh_ticks;
  logic [15:0] sh_wtime;
  logic [7:0]  sh_store [MEM_DEPTH];

  // Line levels as last driven by the bus master side
  logic bus_scl = 1'b1;
  logic bus_sda = 1'b1;

  i2cee_pkg::res_t drive_q [$];
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  bit          hold_req     = 1'b0;
  int          hold_left    = 0;
  int unsigned cyc          = 0;
  int          n_items      = 0;
  int          n_checked    = 0;
  int          n_err        = 0;
  int          n_commits    = 0;
  int          n_rd_bytes   = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) cyc <= cyc + 1;

  initial begin
    wait (cyc >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cyc, drive_q.size());
    $display("** i2c_eeprom_slave: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- shadow model

  function automatic void shadow_reset();
    sh_phase = i2cee_pkg::PH_IDLE;
    sh_bits  = '0;
    sh_shift = '0;
    sh_addr  = '0;
    sh_scl   = 1'b1;
    sh_sda   = 1'b1;
    sh_drv   = 1'b1;
    sh_busy  = 1'b0;
    sh_ticks = '0;
    sh_wtime = i2cee_pkg::WRITE_TIME_RST;
    for (int i = 0; i < MEM_DEPTH; i++) sh_store[i] = '0;
  endfunction

  function automatic logic [7:0] store_index(input int unsigned a);
    return 8'(a % MEM_DEPTH);
  endfunction

  // Shift one bit in; true once a whole byte is in
  function automatic logic shift_in(input logic b);
    sh_shift = {sh_shift[6:0], b};
    sh_bits  = sh_bits + 4'd1;
    return sh_bits == i2cee_pkg::BYTE_BITS;
  endfunction

  // Next outgoing bit, MSB first
  function automatic logic shift_out();
    logic [7:0] t;
    sh_bits = sh_bits - 4'd1;
    t = sh_shift >> sh_bits;
    return t[0];
  endfunction

  function automatic void load_read_byte();
    sh_phase = i2cee_pkg::PH_TX_DATA;
    sh_bits  = i2cee_pkg::BYTE_BITS;
    sh_shift = sh_store[sh_addr[SH_AW-1:0]];
    sh_drv   = shift_out();
    n_rd_bytes++;
  endfunction

  function automatic void on_scl_fall();
    logic d;
    d = sh_sda;
    case (sh_phase)
      i2cee_pkg::PH_IDLE: sh_drv = 1'b1;
      i2cee_pkg::PH_START: begin
        sh_drv   = 1'b1;
        sh_phase = i2cee_pkg::PH_RX_CMD;
      end
      i2cee_pkg::PH_RX_CMD: begin
        if (shift_in(d)) begin
          if ((sh_shift & i2cee_pkg::CTRL_MASK) == i2cee_pkg::CTRL_ID) begin
            sh_phase = i2cee_pkg::PH_ACK_CMD;
            sh_drv   = 1'b0;
          end else begin
            sh_phase = i2cee_pkg::PH_IDLE;
          end
        end
      end
      i2cee_pkg::PH_ACK_CMD: begin
        sh_drv = 1'b1;
        if ((sh_shift & i2cee_pkg::CTRL_READ) != 8'd0) begin
          load_read_byte();
        end else begin
          sh_phase = i2cee_pkg::PH_RX_ADDR;
          sh_bits  = '0;
          sh_shift = '0;
        end
      end
      i2cee_pkg::PH_RX_ADDR: begin
        if (shift_in(d)) begin
          sh_drv   = 1'b0;
          sh_phase = i2cee_pkg::PH_ACK_ADDR;
          sh_addr  = store_index(sh_shift);
        end
      end
      i2cee_pkg::PH_ACK_ADDR: begin
        sh_drv   = 1'b1;
        sh_phase = i2cee_pkg::PH_RX_DATA;
        sh_bits  = '0;
        sh_shift = '0;
      end
      i2cee_pkg::PH_RX_DATA: begin
        if (shift_in(d)) begin
          sh_drv   = 1'b0;
          sh_phase = i2cee_pkg::PH_ACK_WR;
        end
      end
      i2cee_pkg::PH_ACK_WR: begin
        sh_drv   = 1'b1;
        sh_phase = i2cee_pkg::PH_WRPEND;
      end
      i2cee_pkg::PH_WRPEND: begin
        // a further data byte starts with this edge's bit
        sh_shift = {7'd0, d};
        sh_bits  = 4'd1;
        sh_phase = i2cee_pkg::PH_RX_DATA;
      end
      i2cee_pkg::PH_TX_DATA: begin
        if (sh_bits == 4'd0) begin
          sh_drv   = 1'b1;
          sh_addr  = store_index(int'(sh_addr) + 1);
          sh_phase = i2cee_pkg::PH_ACK_RD;
        end else begin
          sh_drv = shift_out();
        end
      end
      i2cee_pkg::PH_ACK_RD: begin
        if (!d) load_read_byte();
        else sh_phase = i2cee_pkg::PH_IDLE;
      end
      default: sh_drv = 1'b1;
    endcase
  endfunction

  function automatic void on_sda_change();
    if (!sh_scl) return;
    if (sh_sda) begin
      // stop: commit a pending write
      if (sh_phase == i2cee_pkg::PH_WRPEND) begin
        sh_store[sh_addr[SH_AW-1:0]] = sh_shift;
        n_commits++;
        if (sh_wtime != 16'd0) begin
          sh_busy  = 1'b1;
          sh_ticks = sh_wtime;
        end
      end
      sh_phase = i2cee_pkg::PH_IDLE;
    end else if (!sh_busy) begin
      // start, ignored while busy
      sh_phase = i2cee_pkg::PH_START;
      sh_bits  = '0;
      sh_shift = '0;
    end
  endfunction

  function automatic i2cee_pkg::res_t predict_drive(input logic [1:0] cmd, input logic lvl);
    i2cee_pkg::res_t r;
    case (cmd)
      i2cee_pkg::CMD_SCL: begin
        if (lvl != sh_scl) begin
          sh_scl = lvl;
          if (!lvl) on_scl_fall();
        end
      end
      i2cee_pkg::CMD_SDA: begin
        if (lvl != sh_sda) begin
          sh_sda = lvl;
          on_sda_change();
        end
      end
      i2cee_pkg::CMD_TICK: begin
        if (sh_busy) begin
          if (sh_ticks <= 16'd1) begin
            sh_ticks = '0;
            sh_busy  = 1'b0;
          end else begin
            sh_ticks = sh_ticks - 16'd1;
          end
        end
      end
      default: ;
    endcase
    r.sda_drive = sh_drv;
    r.busy_res  = sh_busy;
    return r;
  endfunction

  // ---------------------------------------------------------------- result side

  task automatic flag_mismatch(input string what, input i2cee_pkg::res_t want,
                               input i2cee_pkg::res_t got);
    n_err++;
    if (n_err <= MAX_REPORTS)
      $display("mismatch, %s: expected sda_drive=%b busy=%b, got sda_drive=%b busy=%b",
               what, want.sda_drive, want.busy_res, got.sda_drive, got.busy_res);
  endtask

  // Drive ready at random, or hold it low for a long stretch on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Compare each result word with the oldest expected drive
  always @(posedge clk) begin : check_results
    i2cee_pkg::res_t got;
    i2cee_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.sda_drive = res_if.sda_drive;
      got.busy_res  = res_if.busy_res;
      if (drive_q.size() == 0) begin
        want = '0;
        flag_mismatch("result with nothing expected", want, got);
      end else begin
        want = drive_q.pop_front();
        n_checked++;
        if (got !== want) flag_mismatch($sformatf("word %0d", n_checked), want, got);
      end
    end
  end

  // ---------------------------------------------------------------- event side

  // Offer one event word and hold it until taken; ends at a falling edge
  task automatic send_event(input logic [1:0] cmd, input logic lvl);
    i2cee_pkg::res_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      ev_if.valid <= 1'b0;
      @(negedge clk);
    end
    ev_if.valid   <= 1'b1;
    ev_if.command <= cmd;
    ev_if.level   <= lvl;
    do @(posedge clk); while (!ev_if.ready);
    want = predict_drive(cmd, lvl);
    drive_q.push_back(want);
    if (cmd == i2cee_pkg::CMD_SCL) bus_scl = lvl;
    else if (cmd == i2cee_pkg::CMD_SDA) bus_sda = lvl;
    n_items++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_results_done();
    ev_if.valid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_write_time(input logic [15:0] ticks);
    wait_results_done();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    sh_wtime   = ticks;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_scl(input logic lvl);
    if (bus_scl != lvl) send_event(i2cee_pkg::CMD_SCL, lvl);
  endtask

  task automatic set_sda(input logic lvl);
    if (bus_sda != lvl) send_event(i2cee_pkg::CMD_SDA, lvl);
  endtask

  task automatic send_tick();
    send_event(i2cee_pkg::CMD_TICK, 1'($urandom));
  endtask

  // One SCL pulse with the given SDA level; SCL low on entry and exit
  task automatic send_bit(input logic b);
    set_sda(b);
    set_scl(1'b1);
    set_scl(1'b0);
  endtask

  // Start or repeated start from whatever state the lines are in
  task automatic bus_start();
    if (bus_scl && !bus_sda) set_scl(1'b0);
    if (!bus_scl) begin
      set_sda(1'b1);
      set_scl(1'b1);
    end
    set_sda(1'b0);
    set_scl(1'b0);
  endtask

  task automatic bus_stop();
    if (bus_scl) set_scl(1'b0);
    set_sda(1'b0);
    set_scl(1'b1);
    set_sda(1'b1);
  endtask

  // The data bits MSB first, then the acknowledge clock with SDA released
  task automatic send_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) send_bit(v[i]);
    send_bit(1'b1);
  endtask

  // A byte's data clocks with SDA released, then the master ACK (0) or NACK (1)
  task automatic read_byte(input logic nack);
    repeat (8) send_bit(1'b1);
    send_bit(nack);
  endtask

  task automatic write_cycle(input logic [7:0] ctrl, input logic [7:0] addr,
                             input logic [7:0] data);
    bus_start();
    send_byte(ctrl);
    send_byte(addr);
    send_byte(data);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_line_events();
    src_idle_pct = 27;
    snk_idle_pct = 64;
    send_event(CMD_UNUSED, 1'b0);
    send_event(CMD_UNUSED, 1'b1);
    send_event(i2cee_pkg::CMD_TICK, 1'b0);
    send_event(i2cee_pkg::CMD_TICK, 1'b1);
    // unchanged levels, mixed with plain level changes
    send_event(i2cee_pkg::CMD_SCL, 1'b1);
    send_event(i2cee_pkg::CMD_SDA, 1'b1);
    send_event(i2cee_pkg::CMD_SCL, 1'b0);
    send_event(i2cee_pkg::CMD_SCL, 1'b0);
    send_event(i2cee_pkg::CMD_SDA, 1'b0);
    send_event(i2cee_pkg::CMD_SCL, 1'b1);
    // stop while idle, then start, one SCL pulse and stop
    send_event(i2cee_pkg::CMD_SDA, 1'b1);
    send_event(i2cee_pkg::CMD_SDA, 1'b0);
    send_event(i2cee_pkg::CMD_SCL, 1'b0);
    send_event(i2cee_pkg::CMD_SCL, 1'b1);
    send_event(i2cee_pkg::CMD_SDA, 1'b1);
  endtask

  task automatic test_write_extremes();
    set_write_time(16'd0);
    // top address, all ones, no busy period
    write_cycle(i2cee_pkg::CTRL_ID | 8'h0E, 8'hFF, 8'hFF);
    bus_stop();
    // extra data bytes: only the last one lands
    write_cycle(i2cee_pkg::CTRL_ID, 8'h00, 8'h00);
    send_byte(8'h5A);
    send_byte(8'hC3);
    bus_stop();
    // address beyond the store wraps
    write_cycle(i2cee_pkg::CTRL_ID | 8'h02, 8'h11, 8'h80);
    bus_stop();
  endtask

  task automatic test_read_wrap();
    // set address to the top entry, then read across the wrap
    bus_start();
    send_byte(i2cee_pkg::CTRL_ID);
    send_byte(8'h0F);
    bus_start();
    send_byte(i2cee_pkg::CTRL_ID | i2cee_pkg::CTRL_READ);
    read_byte(1'b0);
    read_byte(1'b0);
    read_byte(1'b1);
    bus_stop();
    // current-address read
    bus_start();
    send_byte(i2cee_pkg::CTRL_ID | 8'h0F);
    read_byte(1'b1);
    bus_stop();
  endtask

  task automatic test_rejected_ctrl();
    bus_start();
    send_byte(8'h51);
    send_byte(8'hFF);
    bus_stop();
    bus_start();
    send_byte(8'hB0);
    read_byte(1'b0);
    bus_stop();
  endtask

  task automatic test_busy_window();
    set_write_time(16'd1);
    write_cycle(i2cee_pkg::CTRL_ID, 8'h03, 8'h3C);
    bus_stop();
    // start while busy is ignored
    bus_start();
    send_byte(i2cee_pkg::CTRL_ID | i2cee_pkg::CTRL_READ);
    bus_stop();
    send_tick();
    send_tick();
    set_write_time(16'd3);
    write_cycle(i2cee_pkg::CTRL_ID, 8'h04, 8'hA5);
    bus_stop();
    repeat (4) send_tick();
  endtask

  task automatic random_reads(input int n);
    for (int i = 0; i < n; i++) read_byte(i == n - 1);
  endtask

  // One random bus transaction, mostly well formed, then some ticks
  task automatic random_transaction();
    int         kind;
    logic [7:0] ctrl;
    kind = $urandom_range(9);
    ctrl = i2cee_pkg::CTRL_ID | {4'd0, 3'($urandom), 1'b0};
    if ($urandom_range(9) == 0) ctrl = 8'($urandom);
    case (kind)
      0, 1, 2, 3: begin
        write_cycle(ctrl & ~i2cee_pkg::CTRL_READ, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(2)) send_byte(8'($urandom));
        if ($urandom_range(9) != 0) bus_stop();
      end
      4, 5, 6: begin
        bus_start();
        send_byte(ctrl | i2cee_pkg::CTRL_READ);
        random_reads($urandom_range(4, 1));
        bus_stop();
      end
      7: begin
        bus_start();
        send_byte(ctrl & ~i2cee_pkg::CTRL_READ);
        send_byte(8'($urandom));
        bus_start();
        send_byte(ctrl | i2cee_pkg::CTRL_READ);
        random_reads($urandom_range(3, 1));
        bus_stop();
      end
      8: begin
        repeat ($urandom_range(15, 3)) send_event(2'($urandom), 1'($urandom));
      end
      default: begin
        // broken transaction
        bus_start();
        repeat ($urandom_range(20, 1)) send_bit(1'($urandom));
        if ($urandom_range(1)) bus_stop();
      end
    endcase
    repeat ($urandom_range(20)) send_tick();
  endtask

  task automatic test_random(input int src_pct, input int snk_pct, input logic [15:0] ticks,
                             input int n);
    int stop_at;
    set_write_time(ticks);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = n_items + n;
    while (n_items < stop_at) random_transaction();
  endtask

  // Hold the output side off while the writer keeps pushing words
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_write_time(16'd2);
    hold_req = 1'b1;
    write_cycle(i2cee_pkg::CTRL_ID, 8'h07, 8'h96);
    bus_stop();
    repeat (3) send_tick();
    bus_start();
    send_byte(i2cee_pkg::CTRL_ID | i2cee_pkg::CTRL_READ);
    random_reads(2);
    bus_stop();
  endtask

  task automatic test_busy_max();
    set_write_time(16'hFFFF);
    write_cycle(i2cee_pkg::CTRL_ID, 8'h0A, 8'h0F);
    bus_stop();
    repeat (5) send_tick();
    bus_start();
    send_byte(i2cee_pkg::CTRL_ID);
    bus_stop();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    ev_if.valid   = 1'b0;
    ev_if.command = i2cee_pkg::CMD_TICK;
    ev_if.level   = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_ni        = 1'b0;
    shadow_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_line_events();
    test_write_extremes();
    test_read_wrap();
    test_rejected_ctrl();
    test_busy_window();
    test_random(27, 64, 16'($urandom_range(30, 1)), 40);
    test_random(64, 27, 16'd0, 40);
    test_random(0, 0, 16'($urandom_range(20, 2)), 40);
    test_backpressure();
    test_busy_max();

    wait_results_done();
    if (drive_q.size() != 0) begin
      n_err += drive_q.size();
      $display("%0d expected results never arrived", drive_q.size());
    end

    $display("Covered %0d line and tick events over three idling mixes, a %0d-cycle output stall",
             n_items, HOLD_CYCLES);
    $display("and busy times 0 to 65535: %0d results, %0d commits, %0d bytes read, %0d mismatches",
             n_checked, n_commits, n_rd_bytes, n_err);
    if (n_err == 0) begin
      $display("** i2c_eeprom_slave: PASSED **");
    end else begin
      $display("** i2c_eeprom_slave: FAILED **");
    end
    $finish;
  end

endmodule
